// File: rtl/sca_pkg.sv
// Shared types, constants and size-class tables of the slab allocator.
package sca_pkg;

	localparam int SLAB_CNT_DEF    = 4;
	localparam int CLASS_COUNT_DEF = 14;

	localparam int SIZE_W = 32;
	localparam int ADDR_W = 22;
	localparam int CNT_W  = 48;
	localparam int LIM_W  = 9;
	localparam int TOP_W  = 13;
	localparam int IDX_W  = 12;
	localparam int CLS_W  = 4;
	localparam int REG_W  = 6;
	localparam int BYTE_W = 17;
	localparam int OFF_W  = 16;

	localparam logic [LIM_W-1:0]  SLAB_LIMIT_RST = 9'd4;
	localparam logic [ADDR_W-1:0] LIVE_MAX       = 22'h3FFFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_OOM       = 3'd2,
		ST_BIG       = 3'd3,
		ST_MISALIGN  = 3'd4,
		ST_NOTFOUND  = 3'd5
	} status_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	// classified request handed from front to back
	typedef struct packed {
		func_t             func;
		logic              nul;
		status_t           status;
		logic [CLS_W-1:0]  cls;
		logic [REG_W-1:0]  region;   // region - 1 on free
		logic [IDX_W-1:0]  idx;      // object index on free
	} item_t;

	// per-slab bookkeeping: stack top and low-water mark
	typedef struct packed {
		logic [TOP_W-1:0] top;
		logic [TOP_W-1:0] lw;
	} meta_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RD,
		B_CHK,
		B_POP,
		B_DONE
	} bstate_t;

	function automatic logic [BYTE_W-1:0] obj_bytes(input logic [CLS_W-1:0] c);
		obj_bytes = BYTE_W'(8) << c;
	endfunction

	function automatic logic [TOP_W-1:0] obj_count(input logic [CLS_W-1:0] c);
		obj_count = (c >= 4'd13) ? TOP_W'(1) : (TOP_W'(4096) >> c);
	endfunction

	// log2 of the object count
	function automatic logic [CLS_W-1:0] count_shift(input logic [CLS_W-1:0] c);
		count_shift = (c >= 4'd12) ? 4'd0 : (4'd12 - c);
	endfunction

	function automatic logic [BYTE_W-1:0] slab_span(input logic [CLS_W-1:0] c);
		slab_span = (c == 4'd13) ? 17'h10000 : 17'h08000;
	endfunction

	function automatic logic [TOP_W-1:0] count_prefix(input logic [CLS_W-1:0] c);
		case (c)
			4'd0:    count_prefix = 13'd0;
			4'd1:    count_prefix = 13'd4096;
			4'd2:    count_prefix = 13'd6144;
			4'd3:    count_prefix = 13'd7168;
			4'd4:    count_prefix = 13'd7680;
			4'd5:    count_prefix = 13'd7936;
			4'd6:    count_prefix = 13'd8064;
			4'd7:    count_prefix = 13'd8128;
			4'd8:    count_prefix = 13'd8160;
			4'd9:    count_prefix = 13'd8176;
			4'd10:   count_prefix = 13'd8184;
			4'd11:   count_prefix = 13'd8188;
			4'd12:   count_prefix = 13'd8190;
			4'd13:   count_prefix = 13'd8191;
			default: count_prefix = 13'd0;
		endcase
	endfunction

endpackage

// File: rtl/sca_if.sv
// Channel interfaces: request, response and configuration write.
interface sca_req_if;
	logic                        valid;
	logic                        ready;
	logic                        func;
	logic [sca_pkg::SIZE_W-1:0]  request_size;
	logic [sca_pkg::ADDR_W-1:0]  free_address;
	modport source (output valid, func, request_size, free_address, input ready);
	modport sink   (input valid, func, request_size, free_address, output ready);
endinterface

interface sca_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [sca_pkg::ADDR_W-1:0]  granted_address;
	logic [sca_pkg::ADDR_W-1:0]  live_bytes;
	logic [sca_pkg::CNT_W-1:0]   alloc_total;
	logic [sca_pkg::CNT_W-1:0]   free_total;
	modport source (output valid, status, granted_address, live_bytes, alloc_total,
		free_total, input ready);
	modport sink   (input valid, status, granted_address, live_bytes, alloc_total,
		free_total, output ready);
endinterface

interface sca_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sca_pkg::LIM_W-1:0]  data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: rtl/sca_front.sv
// Request classifier: size class lookup and free address decode.
module sca_front #(
	parameter int SLAB_CNT    = sca_pkg::SLAB_CNT_DEF,
	parameter int CLASS_COUNT = sca_pkg::CLASS_COUNT_DEF
) (
	sca_req_if.sink         req,
	input  logic            q_full,
	output logic            q_push,
	output sca_pkg::item_t  q_item
);
	localparam int SLAB_TOTAL = CLASS_COUNT * SLAB_CNT;

	logic [sca_pkg::CLS_W-1:0]  acls;
	logic [sca_pkg::CLS_W-1:0]  fcls;
	logic [sca_pkg::REG_W-1:0]  region;
	logic [sca_pkg::REG_W-1:0]  rr;
	logic [sca_pkg::OFF_W-1:0]  off;
	logic [sca_pkg::BYTE_W-1:0] fbytes;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		// alloc: count classes too small for the request
		acls = '0;
		for (int c = 0; c < CLASS_COUNT - 1; c++) begin
			if (req.request_size > sca_pkg::SIZE_W'(sca_pkg::obj_bytes(sca_pkg::CLS_W'(c))))
				acls = acls + 1'b1;
		end
		// free: class from region by range compare
		region = req.free_address[sca_pkg::ADDR_W-1 -: sca_pkg::REG_W];
		rr     = region - 1'b1;
		fcls   = '0;
		for (int k = 1; k < CLASS_COUNT; k++) begin
			if (13'(rr) >= 13'(k * SLAB_CNT))
				fcls = fcls + 1'b1;
		end
		off    = req.free_address[sca_pkg::OFF_W-1:0];
		fbytes = sca_pkg::obj_bytes(fcls);

		q_item        = '0;
		q_item.func   = sca_pkg::func_t'(req.func);
		q_item.status = sca_pkg::ST_OK;
		if (req.func == sca_pkg::FN_ALLOC) begin
			q_item.cls = acls;
			if (req.request_size == '0)
				q_item.status = sca_pkg::ST_ZERO;
			else if (req.request_size >
				sca_pkg::SIZE_W'(sca_pkg::obj_bytes(sca_pkg::CLS_W'(CLASS_COUNT - 1))))
				q_item.status = sca_pkg::ST_BIG;
		end else begin
			q_item.cls    = fcls;
			q_item.region = rr;
			q_item.idx    = sca_pkg::IDX_W'(off >> (fcls + 4'd3));
			if (req.free_address == '0)
				q_item.nul = 1'b1;
			else if (region == '0 || 13'(rr) >= 13'(SLAB_TOTAL))
				q_item.status = sca_pkg::ST_NOTFOUND;
			else if (sca_pkg::BYTE_W'(off) >= sca_pkg::slab_span(fcls))
				q_item.status = sca_pkg::ST_NOTFOUND;
			else if ((sca_pkg::BYTE_W'(off) & (fbytes - 1'b1)) != '0)
				q_item.status = sca_pkg::ST_MISALIGN;
		end
	end
endmodule

// File: rtl/sca_fifo.sv
// Two-entry queue between classifier and executor.
module sca_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sca_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            nempty,
	output sca_pkg::item_t  head
);
	sca_pkg::item_t  mem_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: rtl/sca_back.sv
// Executor: slab scan, free stack pop/push, counters and response register.
module sca_back #(
	parameter int SLAB_CNT    = sca_pkg::SLAB_CNT_DEF,
	parameter int CLASS_COUNT = sca_pkg::CLASS_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sca_pkg::LIM_W-1:0]   slab_limit,
	input  logic                        q_nempty,
	input  sca_pkg::item_t              q_head,
	output logic                        q_pop,
	sca_rsp_if.source                   rsp
);
	localparam int NM  = CLASS_COUNT * SLAB_CNT;
	localparam int MW  = (NM > 1) ? $clog2(NM) : 1;
	localparam int SW  = (SLAB_CNT > 1) ? $clog2(SLAB_CNT) : 1;
	localparam int SCW = $clog2(SLAB_CNT + 1);
	localparam int ND  = SLAB_CNT * 8192;
	localparam int AW  = $clog2(ND);

	sca_pkg::bstate_t  st_q, st_nx;
	sca_pkg::item_t    item_q;
	logic [SCW-1:0]    s_q;
	logic [MW-1:0]     maddr_q;
	logic [AW-1:0]     base_q;
	sca_pkg::status_t  status_q;
	logic [sca_pkg::ADDR_W-1:0] gaddr_q;
	logic              eff_q;
	logic              ident_q;
	logic [sca_pkg::IDX_W-1:0]  idx_q;

	sca_pkg::meta_t    meta_mem [NM];
	sca_pkg::meta_t    meta_rd_q;
	logic [NM-1:0]     mvalid_q;
	logic              mval_q;
	logic [sca_pkg::IDX_W-1:0]  store_mem [ND];
	logic [sca_pkg::IDX_W-1:0]  st_rd_q;

	logic [sca_pkg::ADDR_W-1:0] live_q;
	logic [sca_pkg::CNT_W-1:0]  atot_q;
	logic [sca_pkg::CNT_W-1:0]  ftot_q;
	logic                       ov_q;

	// combinational controls
	logic                  is_alloc;
	logic                  run;
	logic [SW-1:0]         s_sel;
	logic [MW-1:0]         maddr_d;
	logic [AW-1:0]         base_d;
	sca_pkg::meta_t        cur;
	logic [sca_pkg::TOP_W-1:0] cnt_c;
	logic [sca_pkg::TOP_W-1:0] newtop;
	logic                  out_free;
	logic                  meta_we;
	sca_pkg::meta_t        meta_wd;
	logic                  st_we;
	logic                  st_re;
	logic [AW-1:0]         st_addr;
	logic [sca_pkg::IDX_W-1:0]  pop_idx;
	logic [sca_pkg::ADDR_W-1:0] pop_addr;
	logic [sca_pkg::BYTE_W-1:0] ob;
	logic [sca_pkg::ADDR_W:0]   live_sum;
	logic [sca_pkg::ADDR_W-1:0] live_nx;

	assign is_alloc = (item_q.func == sca_pkg::FN_ALLOC);
	assign run      = (sca_pkg::LIM_W'(s_q) < slab_limit) && (s_q < SCW'(SLAB_CNT));
	assign cnt_c    = sca_pkg::obj_count(item_q.cls);
	assign cur      = mval_q ? meta_rd_q : sca_pkg::meta_t'{top: cnt_c, lw: cnt_c};
	assign newtop   = cur.top - 1'b1;
	assign out_free = !ov_q || rsp.ready;
	assign ob       = sca_pkg::obj_bytes(item_q.cls);

	always_comb begin
		if (is_alloc)
			s_sel = s_q[SW-1:0];
		else
			s_sel = SW'(item_q.region - sca_pkg::REG_W'(item_q.cls * SLAB_CNT));
		maddr_d = is_alloc ? (MW'(item_q.cls) * MW'(SLAB_CNT) + MW'(s_sel))
			: MW'(item_q.region);
		base_d  = AW'(sca_pkg::count_prefix(item_q.cls)) * AW'(SLAB_CNT)
			+ (AW'(s_sel) << sca_pkg::count_shift(item_q.cls));
		pop_idx  = ident_q ? idx_q : st_rd_q;
		pop_addr = ((sca_pkg::ADDR_W'(maddr_q) + sca_pkg::ADDR_W'(1)) << sca_pkg::OFF_W)
			+ (sca_pkg::ADDR_W'(pop_idx) << (item_q.cls + 4'd3));
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			sca_pkg::B_IDLE: begin
				if (q_nempty)
					st_nx = (q_head.status != sca_pkg::ST_OK || q_head.nul)
						? sca_pkg::B_DONE : sca_pkg::B_RD;
			end
			sca_pkg::B_RD: begin
				st_nx = (is_alloc && !run) ? sca_pkg::B_DONE : sca_pkg::B_CHK;
			end
			sca_pkg::B_CHK: begin
				if (!is_alloc)
					st_nx = sca_pkg::B_DONE;
				else if (cur.top == '0)
					st_nx = sca_pkg::B_RD;
				else
					st_nx = sca_pkg::B_POP;
			end
			sca_pkg::B_POP:  st_nx = sca_pkg::B_DONE;
			sca_pkg::B_DONE: if (out_free) st_nx = sca_pkg::B_IDLE;
			default:         st_nx = sca_pkg::B_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		q_pop   = 1'b0;
		meta_we = 1'b0;
		meta_wd = cur;
		st_we   = 1'b0;
		st_re   = 1'b0;
		st_addr = base_q + AW'(cur.top);
		case (st_q)
			sca_pkg::B_IDLE: q_pop = q_nempty;
			sca_pkg::B_CHK: begin
				if (is_alloc) begin
					if (cur.top != '0) begin
						meta_we    = 1'b1;
						meta_wd.top = newtop;
						meta_wd.lw  = (newtop < cur.lw) ? newtop : cur.lw;
						st_re      = !(newtop < cur.lw);
						st_addr    = base_q + AW'(newtop);
					end
				end else if (cur.top < cnt_c) begin
					meta_we     = 1'b1;
					meta_wd.top = cur.top + 1'b1;
					st_we       = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		live_sum = {1'b0, live_q} + (sca_pkg::ADDR_W+1)'(ob);
		live_nx  = live_q;
		if (eff_q) begin
			if (is_alloc)
				live_nx = live_sum[sca_pkg::ADDR_W] ? sca_pkg::LIVE_MAX
					: live_sum[sca_pkg::ADDR_W-1:0];
			else
				live_nx = ((sca_pkg::BYTE_W+5)'(live_q) >= (sca_pkg::BYTE_W+5)'(ob))
					? live_q - sca_pkg::ADDR_W'(ob) : '0;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (st_q == sca_pkg::B_RD)
			meta_rd_q <= meta_mem[maddr_d];
		if (meta_we)
			meta_mem[maddr_q] <= meta_wd;
		if (st_we)
			store_mem[st_addr] <= item_q.idx;
		if (st_re)
			st_rd_q <= store_mem[st_addr];
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			sca_pkg::B_IDLE: begin
				item_q   <= q_head;
				status_q <= q_head.status;
				gaddr_q  <= '0;
				eff_q    <= 1'b0;
			end
			sca_pkg::B_RD: begin
				maddr_q <= maddr_d;
				base_q  <= base_d;
				mval_q  <= mvalid_q[maddr_d];
				if (is_alloc && !run)
					status_q <= sca_pkg::ST_OOM;
			end
			sca_pkg::B_CHK: begin
				idx_q   <= sca_pkg::IDX_W'(newtop);
				ident_q <= newtop < cur.lw;
				if (!is_alloc)
					eff_q <= 1'b1;
			end
			sca_pkg::B_POP: begin
				gaddr_q <= pop_addr;
				eff_q   <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= sca_pkg::B_IDLE;
			s_q      <= '0;
			mvalid_q <= '0;
			live_q   <= '0;
			atot_q   <= '0;
			ftot_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (st_q == sca_pkg::B_IDLE)
				s_q <= '0;
			else if (st_q == sca_pkg::B_CHK && cur.top == '0)
				s_q <= s_q + 1'b1;
			if (meta_we)
				mvalid_q[maddr_q] <= 1'b1;
			if (st_q == sca_pkg::B_DONE && out_free)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			if (st_q == sca_pkg::B_DONE && out_free) begin
				live_q <= live_nx;
				if (eff_q && is_alloc)
					atot_q <= atot_q + 1'b1;
				if (eff_q && !is_alloc)
					ftot_q <= ftot_q + 1'b1;
			end
		end
	end

	// response payload register
	always_ff @(posedge clk) begin
		if (st_q == sca_pkg::B_DONE && out_free) begin
			rsp.status          <= status_q;
			rsp.granted_address <= gaddr_q;
			rsp.live_bytes      <= live_nx;
			rsp.alloc_total     <= (eff_q && is_alloc) ? atot_q + 1'b1 : atot_q;
			rsp.free_total      <= (eff_q && !is_alloc) ? ftot_q + 1'b1 : ftot_q;
		end
	end

	assign rsp.valid = ov_q;
endmodule

// File: rtl/size_class_slab_allocator.sv
// Top level of the power-of-two size-class slab allocator.
// Channels: req carries one word per request (func 0 = allocate with
// request_size, func 1 = free of free_address); rsp returns exactly one word
// per request in order: status, granted_address and the running live_bytes,
// alloc_total and free_total after that request. cfg writes slab_limit and is
// always ready; write it only while no request is in flight.
// A request is classified on entry and queued (two entries); the executor
// answers an immediate error or null free directly, reads and updates the
// slab's stack state for a free, and for an allocate probes slab after slab
// until one has room, then pops its free stack. It takes a new request only
// when the last is done, due to its read-then-write of slab and stack state.
// Reset: all slabs hold their full free stacks, counters are zero and
// slab_limit is 4; no sweep is needed, since per-slab valid bits and a
// low-water mark stand in for the initial stack contents.
// A stalled rsp holds its word; the executor finishes its item, then waits,
// and req stalls once the queue fills.
module size_class_slab_allocator #(
	parameter int SLAB_CNT    = sca_pkg::SLAB_CNT_DEF,
	parameter int CLASS_COUNT = sca_pkg::CLASS_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sca_req_if.sink    req,
	sca_rsp_if.source  rsp,
	sca_cfg_if.sink    cfg
);
	logic [sca_pkg::LIM_W-1:0] slab_limit_q;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_nempty;
	sca_pkg::item_t  q_item;
	sca_pkg::item_t  q_head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slab_limit_q <= sca_pkg::SLAB_LIMIT_RST;
		else if (cfg.valid)
			slab_limit_q <= cfg.data;
	end

	// front: classify and decode
	sca_front #(.SLAB_CNT(SLAB_CNT), .CLASS_COUNT(CLASS_COUNT)) u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_item)
	);

	sca_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.nempty    (q_nempty),
		.head      (q_head)
	);

	// back: stack ops and response
	sca_back #(.SLAB_CNT(SLAB_CNT), .CLASS_COUNT(CLASS_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slab_limit (slab_limit_q),
		.q_nempty   (q_nempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rsp        (rsp)
	);
endmodule

// File: rtl/sca_checker.sv
// Port-level checks on the response channel, bound to the top level.
module sca_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [2:0]                  status,
	input logic [sca_pkg::ADDR_W-1:0]  granted_address,
	input logic [sca_pkg::CNT_W-1:0]   alloc_total
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(alloc_total))
		else $error("response word changed while stalled");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != sca_pkg::ST_OK |-> granted_address == '0)
		else $error("failed request carries an address");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status <= sca_pkg::ST_NOTFOUND)
		else $error("status code out of range");
endmodule

bind size_class_slab_allocator sca_checker u_sca_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.granted_address (rsp.granted_address),
	.alloc_total     (rsp.alloc_total)
);
